// ----- hw/rtl/fcd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcd_pkg
// Types, constants and log-domain arithmetic for the frameshift codon decoder.
// ----------------------------------------------------------------------------
package fcd_pkg;

   typedef logic signed [23:0] lp_type;
   typedef logic signed [27:0] wide_type;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_BAD_LEN = 2'd1,
      STATUS_LOADED  = 2'd2
   } status_type;

   typedef enum logic {
      OP_LOAD   = 1'b0,
      OP_DECODE = 1'b1
   } opcode_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_TERM,
      ST_FOLD,
      ST_POST,
      ST_COMB,
      ST_SCORE,
      ST_DONE
   } state_type;

   localparam int MAX_FRAG_LEN = 5;

   localparam logic [2:0] CSR_LOG_EPS     = 3'd0;
   localparam logic [2:0] CSR_LOG_ONE_EPS = 3'd1;
   localparam logic [2:0] CSR_BASE_A      = 3'd2;
   localparam logic [2:0] CSR_BASE_C      = 3'd3;
   localparam logic [2:0] CSR_BASE_G      = 3'd4;
   localparam logic [2:0] CSR_BASE_T      = 3'd5;

   localparam lp_type LP_ZERO = 24'sh800000;
   localparam lp_type LP_MAX  = 24'sh7fffff;
   localparam lp_type LN2     = 24'sd45426;
   localparam lp_type LN3     = 24'sd71998;
   localparam lp_type LN4     = 24'sd90852;
   localparam lp_type LN9     = 24'sd143996;
   localparam lp_type LN10    = 24'sd150903;

   localparam lp_type RST_LOG_EPS     = -24'sd301804;
   localparam lp_type RST_LOG_ONE_EPS = -24'sd659;
   localparam lp_type RST_BASE        = -24'sd90852;

   function automatic lp_type sat(input wide_type v);
      if (v <= wide_type'(LP_ZERO)) return LP_ZERO;
      if (v > wide_type'(LP_MAX)) return LP_MAX;
      return lp_type'(v[23:0]);
   endfunction

   function automatic lp_type lcount(input logic [1:0] k);
      case (k)
         2'd0:    return LP_ZERO;
         2'd1:    return '0;
         2'd2:    return LN2;
         default: return LN3;
      endcase
   endfunction

   // log1p(exp(-i/4)) in Q8.16
   function automatic lp_type soft_lp(input logic [5:0] i);
      case (i)
         6'd0:  return 24'sd45426;  6'd1:  return 24'sd37745;
         6'd2:  return 24'sd31069;  6'd3:  return 24'sd25354;
         6'd4:  return 24'sd20530;  6'd5:  return 24'sd16510;
         6'd6:  return 24'sd13200;  6'd7:  return 24'sd10501;
         6'd8:  return 24'sd8318;   6'd9:  return 24'sd6567;
         6'd10: return 24'sd5170;   6'd11: return 24'sd4061;
         6'd12: return 24'sd3184;   6'd13: return 24'sd2493;
         6'd14: return 24'sd1950;   6'd15: return 24'sd1523;
         6'd16: return 24'sd1189;   6'd17: return 24'sd928;
         6'd18: return 24'sd724;    6'd19: return 24'sd565;
         6'd20: return 24'sd440;    6'd21: return 24'sd343;
         6'd22: return 24'sd267;    6'd23: return 24'sd208;
         6'd24: return 24'sd162;    6'd25: return 24'sd126;
         6'd26: return 24'sd98;     6'd27: return 24'sd77;
         6'd28: return 24'sd60;     6'd29: return 24'sd47;
         6'd30: return 24'sd36;     6'd31: return 24'sd28;
         6'd32: return 24'sd22;     6'd33: return 24'sd17;
         6'd34: return 24'sd13;     6'd35: return 24'sd10;
         6'd36: return 24'sd8;      6'd37: return 24'sd6;
         6'd38: return 24'sd5;      6'd39: return 24'sd4;
         6'd40: return 24'sd3;      6'd41: return 24'sd2;
         6'd42: return 24'sd2;      6'd43: return 24'sd1;
         6'd44: return 24'sd1;      6'd45: return 24'sd1;
         6'd46: return 24'sd1;      6'd47: return 24'sd1;
         default: return '0;
      endcase
   endfunction

   function automatic lp_type ladd(input lp_type a, input lp_type b);
      lp_type hi;
      lp_type lo;
      wide_type d;
      if (a == LP_ZERO) return b;
      if (b == LP_ZERO) return a;
      hi = (a > b) ? a : b;
      lo = (a > b) ? b : a;
      d = wide_type'(hi) - wide_type'(lo);
      if (d[27:14] < 14'd48) return sat(wide_type'(hi) + wide_type'(soft_lp(d[19:14])));
      return hi;
   endfunction

   // saturating log-product of e*ne, f*nf, a constant and up to three terms
   function automatic lp_type lsum5(input lp_type e, input lp_type f,
                                    input logic [2:0] ne, input logic [2:0] nf,
                                    input lp_type cst, input lp_type t0,
                                    input lp_type t1, input lp_type t2,
                                    input logic [2:0] use_t);
      logic lz;
      wide_type s;
      lz = (ne != 3'd0 && e == LP_ZERO) || (nf != 3'd0 && f == LP_ZERO) ||
           (use_t[0] && t0 == LP_ZERO) || (use_t[1] && t1 == LP_ZERO) ||
           (use_t[2] && t2 == LP_ZERO);
      s = wide_type'(e) * wide_type'(ne) + wide_type'(f) * wide_type'(nf) +
          wide_type'(cst) +
          (use_t[0] ? wide_type'(t0) : wide_type'(0)) +
          (use_t[1] ? wide_type'(t1) : wide_type'(0)) +
          (use_t[2] ? wide_type'(t2) : wide_type'(0));
      return lz ? LP_ZERO : sat(s);
   endfunction

endpackage

// ----- hw/rtl/fcd_req_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcd_req_if
// Request channel: table loads and fragment decodes.
// ----------------------------------------------------------------------------
interface fcd_req_if import fcd_pkg::*; ();
   logic       valid;
   logic       ready;
   opcode_type opcode;
   logic [5:0] codon_index;
   lp_type     codon_lprob;
   logic [2:0] frag_len;
   logic [1:0] sym0;
   logic [1:0] sym1;
   logic [1:0] sym2;
   logic [1:0] sym3;
   logic [1:0] sym4;

   modport source (output valid, opcode, codon_index, codon_lprob, frag_len,
                   sym0, sym1, sym2, sym3, sym4, input ready);
   modport sink (input valid, opcode, codon_index, codon_lprob, frag_len,
                 sym0, sym1, sym2, sym3, sym4, output ready);
endinterface

// ----- hw/rtl/fcd_rsp_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcd_rsp_if
// Response channel: best codon, its score and status.
// ----------------------------------------------------------------------------
interface fcd_rsp_if import fcd_pkg::*; ();
   logic       valid;
   logic       ready;
   logic [5:0] best_codon;
   lp_type     best_lprob;
   status_type status;

   modport source (output valid, best_codon, best_lprob, status, input ready);
   modport sink (input valid, best_codon, best_lprob, status, output ready);
endinterface

// ----- hw/rtl/fcd_term.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcd_term
// One emission term of the frameshift model for a codon, fragment and step.
// ----------------------------------------------------------------------------
module fcd_term import fcd_pkg::*; (
   input  logic [2:0] frag_len,
   input  logic [4:0] step,
   input  logic [5:0] codon,
   input  logic [1:0] sym [MAX_FRAG_LEN],
   input  lp_type     blp [MAX_FRAG_LEN],
   input  lp_type     log_eps,
   input  lp_type     log_one_eps,
   output lp_type     term
);

   typedef enum logic [1:0] {
      CNT_ONE,
      CNT_TWO,
      CNT_PAIR,
      CNT_TRIPLE
   } cnt_kind_type;

   logic [1:0]              x [3];
   logic [MAX_FRAG_LEN-1:0] mt [3];
   logic [2:0]   ne, nf;
   lp_type       cst;
   cnt_kind_type kind;
   logic [2:0]   j0, j1, j2, bi0, bi1, kk;
   logic [1:0]   ca, cb, g, cnt;
   logic [4:0]   n;
   logic [2:0]   pi;
   logic         ub0, ub1;

   assign x[0] = codon[5:4];
   assign x[1] = codon[3:2];
   assign x[2] = codon[1:0];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < MAX_FRAG_LEN; j++) begin
            mt[i][j] = (x[i] == sym[j]);
         end
      end
   end

   always_comb begin
      ne = '0; nf = '0; cst = '0; kind = CNT_TRIPLE;
      j0 = 3'd0; j1 = 3'd1; j2 = 3'd2; ca = 2'd0; cb = 2'd1;
      ub0 = 1'b0; ub1 = 1'b0; bi0 = 3'd0; bi1 = 3'd0;
      kk = 3'd0; n = '0; g = '0; pi = '0;
      case (frag_len)
         3'd1: begin
            ne = 3'd2; nf = 3'd2; cst = -LN3; kind = CNT_ONE; j0 = 3'd0;
         end
         3'd2: begin
            case (step)
               5'd0: begin
                  ne = 3'd1; nf = 3'd3; cst = LN2 - LN3; kind = CNT_TWO;
                  j0 = 3'd0; j1 = 3'd1;
               end
               5'd1: begin
                  ne = 3'd3; nf = 3'd1; cst = -LN3; kind = CNT_ONE; j0 = 3'd0;
                  ub0 = 1'b1; bi0 = 3'd1;
               end
               default: begin
                  ne = 3'd3; nf = 3'd1; cst = -LN3; kind = CNT_ONE; j0 = 3'd1;
                  ub0 = 1'b1; bi0 = 3'd0;
               end
            endcase
         end
         3'd3: begin
            if (step == 5'd0) begin
               nf = 3'd4; kind = CNT_TRIPLE;
            end else if (step <= 5'd3) begin
               kk = 3'(step - 5'd1);
               ne = 3'd2; nf = 3'd2; cst = LN4 - LN9; kind = CNT_TWO;
               j0 = (kk == 3'd0) ? 3'd1 : 3'd0;
               j1 = (kk == 3'd2) ? 3'd1 : 3'd2;
               ub0 = 1'b1; bi0 = kk;
            end else begin
               kk = 3'(5'd6 - step);
               ne = 3'd4; cst = -LN9; kind = CNT_ONE; j0 = kk;
               ub0 = 1'b1; bi0 = (kk == 3'd0) ? 3'd1 : 3'd0;
               ub1 = 1'b1; bi1 = (kk == 3'd2) ? 3'd1 : 3'd2;
            end
         end
         3'd4: begin
            if (step <= 5'd3) begin
               kk = step[2:0];
               kind = CNT_TRIPLE;
               j0 = (kk == 3'd0) ? 3'd1 : 3'd0;
               j1 = (kk <= 3'd1) ? 3'd2 : 3'd1;
               j2 = (kk <= 3'd2) ? 3'd3 : 3'd2;
               ub0 = 1'b1; bi0 = kk;
            end else begin
               n  = step - 5'd4;
               g  = (n < 5'd6) ? 2'd0 : ((n < 5'd12) ? 2'd1 : 2'd2);
               pi = 3'(n - 5'd6 * {3'd0, g});
               kind = CNT_PAIR;
               ca = (g == 2'd0) ? 2'd1 : 2'd0;
               cb = (g == 2'd2) ? 2'd1 : 2'd2;
               ub0 = 1'b1; ub1 = 1'b1;
               case (pi)
                  3'd0:    begin bi0 = 3'd0; bi1 = 3'd1; j0 = 3'd2; j1 = 3'd3; end
                  3'd1:    begin bi0 = 3'd0; bi1 = 3'd2; j0 = 3'd1; j1 = 3'd3; end
                  3'd2:    begin bi0 = 3'd0; bi1 = 3'd3; j0 = 3'd1; j1 = 3'd2; end
                  3'd3:    begin bi0 = 3'd1; bi1 = 3'd2; j0 = 3'd0; j1 = 3'd3; end
                  3'd4:    begin bi0 = 3'd1; bi1 = 3'd3; j0 = 3'd0; j1 = 3'd2; end
                  default: begin bi0 = 3'd2; bi1 = 3'd3; j0 = 3'd0; j1 = 3'd1; end
               endcase
            end
         end
         default: begin
            kind = CNT_TRIPLE; ub0 = 1'b1; ub1 = 1'b1;
            case (step)
               5'd0: begin bi0 = 3'd0; bi1 = 3'd1; j0 = 3'd2; j1 = 3'd3; j2 = 3'd4; end
               5'd1: begin bi0 = 3'd0; bi1 = 3'd2; j0 = 3'd1; j1 = 3'd3; j2 = 3'd4; end
               5'd2: begin bi0 = 3'd0; bi1 = 3'd3; j0 = 3'd1; j1 = 3'd2; j2 = 3'd4; end
               5'd3: begin bi0 = 3'd0; bi1 = 3'd4; j0 = 3'd1; j1 = 3'd2; j2 = 3'd3; end
               5'd4: begin bi0 = 3'd1; bi1 = 3'd2; j0 = 3'd0; j1 = 3'd3; j2 = 3'd4; end
               5'd5: begin bi0 = 3'd1; bi1 = 3'd3; j0 = 3'd0; j1 = 3'd2; j2 = 3'd4; end
               5'd6: begin bi0 = 3'd1; bi1 = 3'd4; j0 = 3'd0; j1 = 3'd2; j2 = 3'd3; end
               5'd7: begin bi0 = 3'd2; bi1 = 3'd3; j0 = 3'd0; j1 = 3'd1; j2 = 3'd4; end
               5'd8: begin bi0 = 3'd2; bi1 = 3'd4; j0 = 3'd0; j1 = 3'd1; j2 = 3'd3; end
               default: begin
                  bi0 = 3'd3; bi1 = 3'd4; j0 = 3'd0; j1 = 3'd1; j2 = 3'd2;
               end
            endcase
         end
      endcase
   end

   always_comb begin
      case (kind)
         CNT_ONE:  cnt = {1'b0, mt[0][j0]} + {1'b0, mt[1][j0]} + {1'b0, mt[2][j0]};
         CNT_TWO:  cnt = {1'b0, mt[1][j0] & mt[2][j1]} + {1'b0, mt[0][j0] & mt[2][j1]} +
                         {1'b0, mt[0][j0] & mt[1][j1]};
         CNT_PAIR: cnt = {1'b0, mt[ca][j0] & mt[cb][j1]};
         default:  cnt = {1'b0, mt[0][j0] & mt[1][j1] & mt[2][j2]};
      endcase
   end

   assign term = lsum5(log_eps, log_one_eps, ne, nf, cst, lcount(cnt), blp[bi0], blp[bi1],
                       {ub1, ub0, 1'b1});

endmodule

// ----- hw/rtl/frameshift_codon_decoder.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frameshift_codon_decoder
// Scores a 1 to 5 nucleotide fragment against all 64 codons and returns the
// best one; table loads write the codon marginal log probabilities.
// ----------------------------------------------------------------------------
// A load or a fragment of bad length is answered in the cycle after
// acceptance. A decode walks codons 0 to 63, reading the codon table memory
// once per codon, and builds each codon's score with one shared term unit and
// one log-add stage: each term is formed in ST_TERM and folded in ST_FOLD,
// then ST_POST, ST_COMB and ST_SCORE close the codon (ST_POST twice for a
// four-nucleotide fragment). Lengths 1 to 5 take 1, 3, 7, 22 or 10 terms.
// The codon table powers up unknown; load every entry before decoding.
// ----------------------------------------------------------------------------
module frameshift_codon_decoder import fcd_pkg::*; #(
   parameter int ALPHABET_SIZE = 4
) (
   input  logic         clock,
   input  logic         reset,
   fcd_req_if.sink      req_chan,
   fcd_rsp_if.source    rsp_chan,
   input  logic         csr_wr_en,
   input  logic [2:0]   csr_index,
   input  lp_type       csr_wdata
);

   localparam logic [2:0] ALPHA = 3'(ALPHABET_SIZE);

   state_type  state_ff, state_in;
   lp_type     log_eps_ff, log_one_eps_ff;
   lp_type     base_ff [4];
   lp_type     tab_mem [64];
   lp_type     tab_rd_ff;
   logic [2:0] len_ff;
   logic [1:0] sym_ff [MAX_FRAG_LEN];
   lp_type     blp [MAX_FRAG_LEN];
   logic [5:0] codon_ff;
   logic [4:0] step_ff;
   lp_type     term, term_ff, acc_ff, g0_ff, grp_ff, score_ff, best_ff, grp, sc;
   logic [5:0] bestc_ff;
   logic       rsp_valid_ff;
   logic [5:0] rsp_codon_ff;
   lp_type     rsp_lprob_ff;
   status_type rsp_status_ff;
   logic       out_free, req_accept, is_load, bad_len, len4, last_grp, first_grp;
   logic       codon_ok, tab_we, req_ready;
   logic [2:0] post_ne, post_nf;
   lp_type     post_cst;

   function automatic logic [4:0] term_count(input logic [2:0] len);
      case (len)
         3'd1:    return 5'd1;
         3'd2:    return 5'd3;
         3'd3:    return 5'd7;
         3'd4:    return 5'd22;
         default: return 5'd10;
      endcase
   endfunction

   assign out_free   = !rsp_valid_ff || rsp_chan.ready;
   assign req_accept = req_chan.valid && req_ready;
   assign is_load    = (req_chan.opcode == OP_LOAD);
   assign bad_len    = (req_chan.frag_len == 3'd0) || (req_chan.frag_len > 3'(MAX_FRAG_LEN));
   assign len4       = (len_ff == 3'd4);
   assign last_grp   = (len4 && step_ff == 5'd3) || (step_ff == term_count(len_ff) - 5'd1);
   assign first_grp  = (step_ff == 5'd0) || (len4 && step_ff == 5'd4);
   assign codon_ok   = ({1'b0, codon_ff[5:4]} < ALPHA) && ({1'b0, codon_ff[3:2]} < ALPHA) &&
                       ({1'b0, codon_ff[1:0]} < ALPHA);

   always_comb begin
      for (int j = 0; j < MAX_FRAG_LEN; j++) begin
         blp[j] = base_ff[sym_ff[j]];
      end
   end

   fcd_term u_term (
      .frag_len    (len_ff),
      .step        (step_ff),
      .codon       (codon_ff),
      .sym         (sym_ff),
      .blp         (blp),
      .log_eps     (log_eps_ff),
      .log_one_eps (log_one_eps_ff),
      .term        (term)
   );

   always_comb begin
      post_ne = 3'd0; post_nf = 3'd0; post_cst = '0;
      case (len_ff)
         3'd4: begin
            if (step_ff == 5'd3) begin
               post_ne = 3'd1; post_nf = 3'd3; post_cst = -LN2;
            end else begin
               post_ne = 3'd3; post_nf = 3'd1; post_cst = -LN9;
            end
         end
         3'd5: begin
            post_ne = 3'd2; post_nf = 3'd2; post_cst = -LN10;
         end
         default: begin
            post_ne = 3'd0; post_nf = 3'd0; post_cst = '0;
         end
      endcase
   end

   assign grp = lsum5(log_eps_ff, log_one_eps_ff, post_ne, post_nf, post_cst, acc_ff,
                      '0, '0, 3'b001);
   assign sc  = lsum5(log_eps_ff, log_one_eps_ff, 3'd0, 3'd0, '0, score_ff, tab_rd_ff,
                      '0, 3'b011);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (req_accept && !is_load && !bad_len) state_in = ST_TERM;
         ST_TERM:  state_in = ST_FOLD;
         ST_FOLD:  state_in = last_grp ? ST_POST : ST_TERM;
         ST_POST:  state_in = (len4 && step_ff == 5'd3) ? ST_TERM : ST_COMB;
         ST_COMB:  state_in = ST_SCORE;
         ST_SCORE: state_in = (&codon_ff) ? ST_DONE : ST_TERM;
         ST_DONE:  if (out_free) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      tab_we    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = out_free;
            tab_we    = req_chan.valid && out_free && is_load;
         end
         default: begin
            req_ready = 1'b0;
            tab_we    = 1'b0;
         end
      endcase
   end

   assign req_chan.ready      = req_ready;
   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.best_codon = rsp_codon_ff;
   assign rsp_chan.best_lprob = rsp_lprob_ff;
   assign rsp_chan.status     = rsp_status_ff;

   always_ff @(posedge clock) begin
      if (tab_we) begin
         tab_mem[req_chan.codon_index] <= req_chan.codon_lprob;
      end
      tab_rd_ff <= tab_mem[codon_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         log_eps_ff     <= RST_LOG_EPS;
         log_one_eps_ff <= RST_LOG_ONE_EPS;
         for (int i = 0; i < 4; i++) begin
            base_ff[i] <= RST_BASE;
         end
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_LOG_EPS:     log_eps_ff     <= csr_wdata;
            CSR_LOG_ONE_EPS: log_one_eps_ff <= csr_wdata;
            CSR_BASE_A:      base_ff[0]     <= csr_wdata;
            CSR_BASE_C:      base_ff[1]     <= csr_wdata;
            CSR_BASE_G:      base_ff[2]     <= csr_wdata;
            CSR_BASE_T:      base_ff[3]     <= csr_wdata;
            default:         ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               len_ff    <= req_chan.frag_len;
               sym_ff[0] <= req_chan.sym0;
               sym_ff[1] <= req_chan.sym1;
               sym_ff[2] <= req_chan.sym2;
               sym_ff[3] <= req_chan.sym3;
               sym_ff[4] <= req_chan.sym4;
               codon_ff  <= '0;
               step_ff   <= '0;
               best_ff   <= LP_ZERO;
               bestc_ff  <= '0;
            end
         end
         ST_TERM: term_ff <= term;
         ST_FOLD: begin
            acc_ff <= first_grp ? term_ff : ladd(acc_ff, term_ff);
            if (!last_grp) step_ff <= step_ff + 5'd1;
         end
         ST_POST: begin
            if (len4 && step_ff == 5'd3) begin
               g0_ff   <= grp;
               step_ff <= step_ff + 5'd1;
            end else begin
               grp_ff <= grp;
            end
         end
         ST_COMB: score_ff <= len4 ? ladd(g0_ff, grp_ff) : grp_ff;
         ST_SCORE: begin
            if (codon_ok && sc >= best_ff) begin
               best_ff  <= sc;
               bestc_ff <= codon_ff;
            end
            codon_ff <= codon_ff + 6'd1;
            step_ff  <= '0;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_accept && (is_load || bad_len)) begin
         rsp_valid_ff <= 1'b1;
      end else if (state_ff == ST_DONE && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept && is_load) begin
         rsp_codon_ff  <= '0;
         rsp_lprob_ff  <= '0;
         rsp_status_ff <= STATUS_LOADED;
      end else if (req_accept && bad_len) begin
         rsp_codon_ff  <= '0;
         rsp_lprob_ff  <= LP_ZERO;
         rsp_status_ff <= STATUS_BAD_LEN;
      end else if (state_ff == ST_DONE && out_free) begin
         rsp_codon_ff  <= bestc_ff;
         rsp_lprob_ff  <= best_ff;
         rsp_status_ff <= STATUS_OK;
      end
   end

   a_load_answers: assert property (@(posedge clock) disable iff (reset)
      req_accept && is_load |=> rsp_valid_ff && rsp_status_ff == STATUS_LOADED)
      else $error("load word not answered with load status");

   a_bad_len_answers: assert property (@(posedge clock) disable iff (reset)
      req_accept && !is_load && bad_len |=>
         rsp_valid_ff && rsp_status_ff == STATUS_BAD_LEN && rsp_lprob_ff == LP_ZERO)
      else $error("bad length word not answered");

   a_step_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_TERM || state_ff == ST_FOLD) |-> step_ff < term_count(len_ff))
      else $error("term step beyond term count");

   a_next_codon: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCORE && !(&codon_ff) |=> state_ff == ST_TERM && step_ff == 5'd0)
      else $error("codon walk did not restart term sequence");

   a_busy_blocks_req: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_IDLE |-> !req_chan.ready)
      else $error("request accepted during decode");

endmodule

// ----- tb/tb_frameshift_codon_decoder.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_frameshift_codon_decoder
// Self-checking bench for the frameshift codon decoder. It fills the codon
// table and runs a short directed table: invalid lengths, all-log-zero ties,
// extreme entries and symbols. It then runs four random phases, each with its
// own register setting: random values, zeros, log zero and the reset values.
// A local scoring model predicts each response word not fixed by a directed
// row. Random gaps and stalls on both channels; one long response hold-off.
// ----------------------------------------------------------------------------
module tb_frameshift_codon_decoder;
   import fcd_pkg::*;

   localparam int LZ       = -8388608;
   localparam int LMAX     = 8388607;
   localparam int K_LN2    = LN2;
   localparam int K_LN4    = LN4;
   localparam int K_LN3    = LN3;
   localparam int K_LN9    = LN9;
   localparam int K_LN10   = LN10;
   localparam int IDLE_CAP = 50000;
   localparam int SQUEEZE  = 5000;
   localparam int PHASE_N  = 116;

   localparam int SOFTTAB[48] = '{
      45426, 37745, 31069, 25354, 20530, 16510, 13200, 10501,
      8318, 6567, 5170, 4061, 3184, 2493, 1950, 1523,
      1189, 928, 724, 565, 440, 343, 267, 208,
      162, 126, 98, 77, 60, 47, 36, 28,
      22, 17, 13, 10, 8, 6, 5, 4,
      3, 2, 2, 1, 1, 1, 1, 1};

   typedef struct {
      opcode_type op;
      int         idx;
      int         lp;
      int         len;
      int         sym[5];
      bit         typed;
      int         t_codon;
      int         t_lp;
      status_type t_status;
   } frag_word_type;

   typedef struct {
      int         codon;
      int         lp;
      status_type status;
   } answer_type;

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic [2:0] csr_index;
   lp_type csr_wdata;

   fcd_req_if req ();
   fcd_rsp_if rsp ();

   frameshift_codon_decoder u_top (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req),
      .rsp_chan  (rsp),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   int cfg_eps;
   int cfg_keep;
   int cfg_base[4];
   int codon_mem[64];
   answer_type pending_answers[$];
   frag_word_type dir_rows[$];
   int mismatches;
   int idle_cycles;
   bit calm;
   bit squeeze_now;

   initial clock = 1'b0;
   always #1 clock = ~clock;

   // ---------------------------------------------------------------- scoring
   function automatic int sat_lp(longint v);
      if (v <= LZ) return LZ;
      if (v > LMAX) return LMAX;
      return int'(v);
   endfunction

   function automatic int lp_sum(int t0, int t1, int t2 = 0, int t3 = 0, int t4 = 0,
                                 int t5 = 0, int t6 = 0, int t7 = 0);
      int t[8];
      longint acc;
      t = '{t0, t1, t2, t3, t4, t5, t6, t7};
      acc = 0;
      for (int i = 0; i < 8; i++) begin
         if (t[i] == LZ) return LZ;
         acc += t[i];
      end
      return sat_lp(acc);
   endfunction

   function automatic int lp_add(int a, int b);
      int hi;
      int lo;
      longint d;
      if (a == LZ) return b;
      if (b == LZ) return a;
      hi = a > b ? a : b;
      lo = a > b ? b : a;
      d = longint'(hi) - lo;
      if ((d >>> 14) < 48) return sat_lp(longint'(hi) + SOFTTAB[d >>> 14]);
      return hi;
   endfunction

   function automatic int lp_fold(int n, int v[18]);
      int acc;
      acc = v[0];
      for (int i = 1; i < n; i++) acc = lp_add(acc, v[i]);
      return acc;
   endfunction

   function automatic int match_log(int k);
      if (k <= 0) return LZ;
      if (k == 1) return 0;
      if (k == 2) return K_LN2;
      return K_LN3;
   endfunction

   function automatic int pair_hits(int mm[3][5], int r, int s);
      return mm[1][r] * mm[2][s] + mm[0][r] * mm[2][s] + mm[0][r] * mm[1][s];
   endfunction

   function automatic int frag_emission(int len, int x[3], int z[5], int b[5]);
      int e;
      int f;
      int mm[3][5];
      int v[18];
      int w[18];
      int c1[5];
      int r;
      int s;
      int n;
      int ca;
      int cb;
      int kp[3];
      int c;
      e = cfg_eps;
      f = cfg_keep;
      for (int i = 0; i < 3; i++)
         for (int j = 0; j < 5; j++) mm[i][j] = (x[i] == z[j]);
      for (int j = 0; j < 5; j++) c1[j] = mm[0][j] + mm[1][j] + mm[2][j];
      if (len == 1) return lp_sum(e, e, f, f, match_log(c1[0]), -K_LN3);
      if (len == 2) begin
         v[0] = lp_sum(K_LN2, e, f, f, f, -K_LN3, match_log(pair_hits(mm, 0, 1)));
         v[1] = lp_sum(e, e, e, f, -K_LN3, match_log(c1[0]), b[1]);
         v[2] = lp_sum(e, e, e, f, -K_LN3, match_log(c1[1]), b[0]);
         return lp_fold(3, v);
      end
      if (len == 3) begin
         v[0] = lp_sum(f, f, f, f, match_log(mm[0][0] * mm[1][1] * mm[2][2]));
         for (int k = 0; k < 3; k++) begin
            r = k == 0 ? 1 : 0;
            s = k == 2 ? 1 : 2;
            v[1 + k] = lp_sum(K_LN4, e, e, f, f, -K_LN9, match_log(pair_hits(mm, r, s)), b[k]);
            v[6 - k] = lp_sum(e, e, e, e, -K_LN9, match_log(c1[k]), b[r], b[s]);
         end
         return lp_fold(7, v);
      end
      if (len == 4) begin
         for (int k = 0; k < 4; k++) begin
            c = 0;
            for (int t = 0; t < 4; t++) if (t != k) begin
               kp[c] = t;
               c++;
            end
            w[k] = lp_sum(match_log(mm[0][kp[0]] * mm[1][kp[1]] * mm[2][kp[2]]), b[k]);
         end
         n = 0;
         for (int g = 0; g < 3; g++) begin
            ca = g == 0 ? 1 : 0;
            cb = g == 2 ? 1 : 2;
            for (int p = 0; p < 4; p++)
               for (int q = p + 1; q < 4; q++) begin
                  c = 0;
                  for (int t = 0; t < 4; t++) if (t != p && t != q) begin
                     kp[c] = t;
                     c++;
                  end
                  v[n] = lp_sum(match_log(mm[ca][kp[0]] * mm[cb][kp[1]]), b[p], b[q]);
                  n++;
               end
         end
         return lp_add(lp_sum(e, f, f, f, -K_LN2, lp_fold(4, w)),
                       lp_sum(e, e, e, f, -K_LN9, lp_fold(18, v)));
      end
      n = 0;
      for (int p = 0; p < 5; p++)
         for (int q = p + 1; q < 5; q++) begin
            c = 0;
            for (int t = 0; t < 5; t++) if (t != p && t != q) begin
               kp[c] = t;
               c++;
            end
            v[n] = lp_sum(b[p], b[q], match_log(mm[0][kp[0]] * mm[1][kp[1]] * mm[2][kp[2]]));
            n++;
         end
      return lp_sum(e, e, f, f, -K_LN10, lp_fold(10, v));
   endfunction

   function automatic answer_type best_codon_of(frag_word_type wd);
      answer_type a;
      int x[3];
      int b[5];
      int sc;
      if (wd.op == OP_LOAD) begin
         codon_mem[wd.idx] = wd.lp;
         a = '{0, 0, STATUS_LOADED};
         return a;
      end
      if (wd.len < 1 || wd.len > MAX_FRAG_LEN) begin
         a = '{0, LZ, STATUS_BAD_LEN};
         return a;
      end
      for (int j = 0; j < 5; j++) b[j] = cfg_base[wd.sym[j]];
      a = '{0, LZ, STATUS_OK};
      for (int cd = 0; cd < 64; cd++) begin
         x = '{cd / 16, (cd / 4) % 4, cd % 4};
         sc = lp_sum(frag_emission(wd.len, x, wd.sym, b), codon_mem[cd]);
         if (sc >= a.lp) begin
            a.lp = sc;
            a.codon = cd;
         end
      end
      return a;
   endfunction

   // ---------------------------------------------------------------- words
   function automatic frag_word_type mk_word(opcode_type op, int idx, int lp, int len,
                                             int s0, int s1, int s2, int s3, int s4);
      frag_word_type wd;
      wd.op = op;
      wd.idx = idx;
      wd.lp = lp;
      wd.len = len;
      wd.sym = '{s0, s1, s2, s3, s4};
      wd.typed = 1'b0;
      wd.t_codon = 0;
      wd.t_lp = 0;
      wd.t_status = STATUS_OK;
      return wd;
   endfunction

   function automatic frag_word_type mk_typed(frag_word_type wd, int cd, int lp,
                                              status_type st);
      wd.typed = 1'b1;
      wd.t_codon = cd;
      wd.t_lp = lp;
      wd.t_status = st;
      return wd;
   endfunction

   function automatic int rand_lp();
      int k;
      k = $urandom_range(0, 9);
      if (k == 0) return LZ;
      if (k == 1) return 0;
      if (k == 2) return -int'($urandom_range(0, 8388608));
      return -int'($urandom_range(0, 1 << 20));
   endfunction

   function automatic frag_word_type rand_word();
      int k;
      int len;
      k = $urandom_range(0, 99);
      if (k < 45)
         return mk_word(OP_LOAD, $urandom_range(0, 63), rand_lp(), $urandom_range(0, 7),
                        $urandom_range(0, 3), $urandom_range(0, 3), $urandom_range(0, 3),
                        $urandom_range(0, 3), $urandom_range(0, 3));
      if (k < 55) len = $urandom_range(0, 1) ? 0 : $urandom_range(6, 7);
      else if (k < 65) len = 1;
      else if (k < 75) len = 2;
      else if (k < 85) len = 3;
      else if (k < 94) len = 5;
      else len = 4;
      return mk_word(OP_DECODE, $urandom_range(0, 63), -int'($urandom_range(0, 8388608)), len,
                     $urandom_range(0, 3), $urandom_range(0, 3), $urandom_range(0, 3),
                     $urandom_range(0, 3), $urandom_range(0, 3));
   endfunction

   // ---------------------------------------------------------------- request side
   task automatic offer_word(frag_word_type wd);
      int gap;
      answer_type a;
      gap = 0;
      if (!calm) begin
         case ($urandom_range(0, 9))
            0, 1, 2:  gap = $urandom_range(1, 3);
            3:        gap = $urandom_range(10, 60);
            default:  gap = 0;
         endcase
      end
      if (gap > 0) begin
         req.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req.valid       <= 1'b1;
      req.opcode      <= wd.op;
      req.codon_index <= wd.idx[5:0];
      req.codon_lprob <= lp_type'(wd.lp);
      req.frag_len    <= wd.len[2:0];
      req.sym0        <= wd.sym[0][1:0];
      req.sym1        <= wd.sym[1][1:0];
      req.sym2        <= wd.sym[2][1:0];
      req.sym3        <= wd.sym[3][1:0];
      req.sym4        <= wd.sym[4][1:0];
      do @(posedge clock); while (!req.ready);
      a = best_codon_of(wd);
      if (wd.typed) a = '{wd.t_codon, wd.t_lp, wd.t_status};
      pending_answers.push_back(a);
   endtask

   task automatic drain();
      req.valid <= 1'b0;
      @(posedge clock);
      while (pending_answers.size() != 0) @(posedge clock);
   endtask

   task automatic csr_write(logic [2:0] idx, int val);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= lp_type'(val);
      @(posedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         CSR_LOG_EPS:     cfg_eps = val;
         CSR_LOG_ONE_EPS: cfg_keep = val;
         CSR_BASE_A:      cfg_base[0] = val;
         CSR_BASE_C:      cfg_base[1] = val;
         CSR_BASE_G:      cfg_base[2] = val;
         CSR_BASE_T:      cfg_base[3] = val;
         default:         ;
      endcase
   endtask

   task automatic program_phase(int ph);
      int v[6];
      case (ph)
         0: for (int i = 0; i < 6; i++) v[i] = -int'($urandom_range(1000, 1 << 19));
         1: v = '{0, 0, 0, 0, 0, 0};
         2: v = '{LZ, LZ, LZ, -int'($urandom_range(0, 200000)), 0, LZ};
         default: v = '{RST_LOG_EPS, RST_LOG_ONE_EPS, RST_BASE, RST_BASE, RST_BASE, RST_BASE};
      endcase
      csr_write(CSR_LOG_EPS, v[0]);
      csr_write(CSR_LOG_ONE_EPS, v[1]);
      csr_write(CSR_BASE_A, v[2]);
      csr_write(CSR_BASE_C, v[3]);
      csr_write(CSR_BASE_G, v[4]);
      csr_write(CSR_BASE_T, v[5]);
   endtask

   initial begin
      reset       <= 1'b1;
      csr_wr_en   <= 1'b0;
      csr_index   <= CSR_LOG_EPS;
      csr_wdata   <= '0;
      req.valid   <= 1'b0;
      req.opcode  <= OP_LOAD;
      req.codon_index <= '0;
      req.codon_lprob <= '0;
      req.frag_len    <= '0;
      req.sym0 <= '0;
      req.sym1 <= '0;
      req.sym2 <= '0;
      req.sym3 <= '0;
      req.sym4 <= '0;
      cfg_eps = RST_LOG_EPS;
      cfg_keep = RST_LOG_ONE_EPS;
      cfg_base = '{RST_BASE, RST_BASE, RST_BASE, RST_BASE};
      codon_mem = '{default: 0};
      mismatches = 0;
      calm = 1'b0;
      squeeze_now = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // fill the table with log zero: every score ties and the last codon wins
      for (int i = 0; i < 64; i++)
         offer_word(mk_typed(mk_word(OP_LOAD, i, LZ, 0, 0, 0, 0, 0, 0), 0, 0, STATUS_LOADED));

      dir_rows.push_back(mk_typed(mk_word(OP_DECODE, 0, 0, 1, 0, 0, 0, 0, 0),
                                  63, LZ, STATUS_OK));
      dir_rows.push_back(mk_typed(mk_word(OP_DECODE, 63, 0, 5, 3, 3, 3, 3, 3),
                                  63, LZ, STATUS_OK));
      dir_rows.push_back(mk_typed(mk_word(OP_DECODE, 0, 0, 0, 0, 0, 0, 0, 0),
                                  0, LZ, STATUS_BAD_LEN));
      dir_rows.push_back(mk_typed(mk_word(OP_DECODE, 63, LZ, 6, 3, 3, 3, 3, 3),
                                  0, LZ, STATUS_BAD_LEN));
      dir_rows.push_back(mk_typed(mk_word(OP_DECODE, 21, -1, 7, 1, 2, 3, 0, 1),
                                  0, LZ, STATUS_BAD_LEN));
      dir_rows.push_back(mk_typed(mk_word(OP_LOAD, 0, 0, 7, 3, 3, 3, 3, 3),
                                  0, 0, STATUS_LOADED));
      dir_rows.push_back(mk_typed(mk_word(OP_LOAD, 63, -1, 0, 0, 0, 0, 0, 0),
                                  0, 0, STATUS_LOADED));
      dir_rows.push_back(mk_word(OP_LOAD, 21, -8388607, 1, 0, 0, 0, 0, 0));
      dir_rows.push_back(mk_word(OP_LOAD, 42, -90852, 1, 0, 0, 0, 0, 0));
      dir_rows.push_back(mk_word(OP_LOAD, 27, -300000, 1, 0, 0, 0, 0, 0));
      for (int l = 1; l <= 5; l++) begin
         dir_rows.push_back(mk_word(OP_DECODE, 0, 0, l, 0, 0, 0, 0, 0));
         dir_rows.push_back(mk_word(OP_DECODE, 63, LZ, l, 3, 3, 3, 3, 3));
      end
      dir_rows.push_back(mk_word(OP_DECODE, 5, 0, 3, 1, 2, 3, 0, 0));
      dir_rows.push_back(mk_word(OP_DECODE, 5, 0, 2, 2, 2, 3, 0, 1));
      dir_rows.push_back(mk_word(OP_DECODE, 5, 0, 5, 1, 2, 3, 0, 2));
      foreach (dir_rows[i]) offer_word(dir_rows[i]);

      for (int ph = 0; ph < 4; ph++) begin
         drain();
         program_phase(ph);
         calm = (ph == 3);
         for (int i = 0; i < PHASE_N; i++) begin
            if (ph == 1 && i == 30) squeeze_now = 1'b1;
            offer_word(rand_word());
         end
      end
      drain();
      repeat (40) @(posedge clock);
      if (mismatches == 0 && pending_answers.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   // ---------------------------------------------------------------- response side
   initial begin
      int stall;
      answer_type a;
      rsp.ready <= 1'b0;
      stall = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp.valid && rsp.ready) begin
            if (pending_answers.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected word: codon %0d lprob %0d status %0d",
                           rsp.best_codon, rsp.best_lprob, rsp.status);
            end else begin
               a = pending_answers.pop_front();
               if (rsp.best_codon !== a.codon[5:0] || rsp.best_lprob !== lp_type'(a.lp) ||
                   rsp.status !== a.status) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: exp codon %0d lprob %0d status %0d, got %0d %0d %0d",
                              a.codon, a.lp, a.status,
                              rsp.best_codon, rsp.best_lprob, rsp.status);
               end
            end
         end
         if (squeeze_now) begin
            squeeze_now = 1'b0;
            stall = SQUEEZE;
         end else if (stall == 0 && !calm && $urandom_range(0, 9) == 0) begin
            stall = $urandom_range(0, 4) == 0 ? $urandom_range(20, 150) : $urandom_range(1, 3);
         end
         if (stall > 0) begin
            stall--;
            rsp.ready <= 1'b0;
         end else begin
            rsp.ready <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------- watchdog
   always @(posedge clock) begin
      if (reset || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_CAP) begin
         $display("*** FAILED ***");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule
